[rtl/bfa_pkg.sv]
// Shared types and constants of the bitmap fixed block allocator.
// No dependencies; every other file of the block imports it.
package bfa_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 256;
  localparam int unsigned GROUP_SIZE_DEF  = 8;

  localparam int unsigned SCAN_W   = 16;
  localparam int unsigned SCAN_LOG = 4;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned MUL_W   = 16;
  localparam int unsigned PADDR_W = 4;

  localparam logic [1:0] REG_GROUP_COUNT = 2'd0;
  localparam logic [1:0] REG_ENTRY_SIZE  = 2'd1;
  localparam logic [1:0] REG_POOL_BASE   = 2'd2;

  localparam logic [5:0]  GROUP_COUNT_RST = 6'd32;
  localparam logic [15:0] ENTRY_SIZE_RST  = 16'd64;
  localparam logic [31:0] POOL_BASE_RST   = 32'd0;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ARITH_ADD,
    ARITH_SUB,
    ARITH_MUL
  } arith_op_e;

  typedef struct packed {
    arith_op_e          op;
    logic [DATA_W-1:0]  a;
    logic [DATA_W-1:0]  b;
  } arith_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  res;
    logic               ge;
  } arith_rsp_t;

  typedef enum logic [1:0] {
    MAP_HOLD,
    MAP_TAKE,
    MAP_GIVE
  } map_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_AMUL,
    S_AADD,
    S_OFFSET,
    S_SPAN,
    S_CMP,
    S_DIV,
    S_FREE,
    S_OUT
  } state_e;

endpackage

[rtl/bfa_arith.sv]
// Shared add, subtract-compare and 16x16 multiply unit of the allocator.
// Depends on bfa_pkg for the request and response types.
module bfa_arith (
  input  bfa_pkg::arith_req_t req_i,
  output bfa_pkg::arith_rsp_t rsp_o
);
  import bfa_pkg::*;

  logic [DATA_W:0]     diff;
  logic [2*MUL_W-1:0]  prod;

  assign diff = {1'b0, req_i.a} - {1'b0, req_i.b};
  assign prod = req_i.a[MUL_W-1:0] * req_i.b[MUL_W-1:0];

  always_comb begin
    rsp_o.ge = ~diff[DATA_W];
    case (req_i.op)
      ARITH_ADD: rsp_o.res = req_i.a + req_i.b;
      ARITH_SUB: rsp_o.res = diff[DATA_W-1:0];
      ARITH_MUL: rsp_o.res = DATA_W'(prod);
      default:   rsp_o.res = '0;
    endcase
  end

endmodule

[rtl/bfa_free_map.sv]
// Free bitmap of the allocator, one bit per entry, 1 = free, reset to all free.
// Depends on bfa_pkg for the scan width and map operation codes.
module bfa_free_map #(
  parameter int unsigned CHUNK_W     = 4,
  parameter int unsigned IDX_W       = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [CHUNK_W-1:0]               chunk_i,
  output logic [bfa_pkg::SCAN_W-1:0]       chunk_bits_o,
  input  bfa_pkg::map_op_e                 op_i,
  input  logic [IDX_W-1:0]                 idx_i
);
  import bfa_pkg::*;

  localparam int unsigned ROWS  = 1 << CHUNK_W;
  localparam int unsigned MAP_W = ROWS * SCAN_W;

  logic [MAP_W-1:0] free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '1;
    end else begin
      for (int unsigned j = 0; j < MAP_W; j++) begin
        if (DATA_W'(idx_i) == DATA_W'(j)) begin
          if (op_i == MAP_TAKE) begin
            free_q[j] <= 1'b0;
          end else if (op_i == MAP_GIVE) begin
            free_q[j] <= 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    chunk_bits_o = '0;
    for (int unsigned c = 0; c < ROWS; c++) begin
      if (chunk_i == CHUNK_W'(c)) begin
        chunk_bits_o = free_q[c*SCAN_W +: SCAN_W];
      end
    end
  end

endmodule

[rtl/bitmap_fixed_block_allocator.sv]
// Top level of the bitmap fixed block allocator: APB register file and sequencer.
// Depends on bfa_pkg, bfa_arith and bfa_free_map.
//
// Each request word is either an allocate (first free entry, lowest index) or
// a release of a byte address; one result word comes back per request, and no
// new request is taken until that result has been delivered. An allocate scans
// the free bitmap sixteen entries a cycle, then forms the address with a
// multiply and then an add on the shared arithmetic unit. A release forms the
// offset, the pool span and the bounds compare, then runs
// ceil(log2(MAX_ENTRIES)) restoring division steps on the same unit and frees
// the entry; an address outside the pool ends after the compare. The result is
// held until it is taken, then the sequencer returns to idle, where the next
// request is taken. The free map resets to all free in the reset cycle itself.
// Registers: group count at 0x0, entry size at 0x4, pool base at 0x8.
module bitmap_fixed_block_allocator #(
  parameter int unsigned MAX_ENTRIES = bfa_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned GROUP_SIZE  = bfa_pkg::GROUP_SIZE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bfa_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [31:0]                   release_address_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          ok_o,
  output logic [7:0]                    entry_index_o,
  output logic [31:0]                   entry_address_o
);
  import bfa_pkg::*;

  localparam int unsigned MAX_GROUPS = MAX_ENTRIES / GROUP_SIZE;
  localparam int unsigned IDX_W      = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W      = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned K_W        = (IDX_W > 1) ? $clog2(IDX_W) : 1;
  localparam int unsigned NCHUNK     = (MAX_ENTRIES + SCAN_W - 1) / SCAN_W;
  localparam int unsigned CHUNK_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

  logic [5:0]  group_count_q;
  logic [15:0] entry_size_q;
  logic [31:0] pool_base_q;

  state_e             state_q, state_d;
  logic [CHUNK_W-1:0] chunk_q, chunk_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [31:0]        addr_q, addr_d;
  logic [31:0]        acc_q, acc_d;
  logic [31:0]        span_q, span_d;
  logic [K_W-1:0]     k_q, k_d;
  logic               ok_q, ok_d;
  logic [7:0]         index_q, index_d;
  logic [31:0]        eaddr_q, eaddr_d;

  arith_req_t          arith_req;
  arith_rsp_t          arith_rsp;
  map_op_e             map_op;
  logic [IDX_W-1:0]    map_idx;
  logic [SCAN_W-1:0]   chunk_bits;
  logic [SCAN_W-1:0]   avail;
  logic [SCAN_LOG-1:0] first;
  logic [31:0]         chunk_base;
  logic [31:0]         found_pos;
  logic [31:0]         groups_sat;
  logic [31:0]         n_full;
  logic [31:0]         n_cap;
  logic [31:0]         idx_ext;
  logic                cfg_wr;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_count_q <= GROUP_COUNT_RST;
      entry_size_q  <= ENTRY_SIZE_RST;
      pool_base_q   <= POOL_BASE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_GROUP_COUNT: group_count_q <= pwdata[5:0];
        REG_ENTRY_SIZE:  entry_size_q  <= pwdata[15:0];
        REG_POOL_BASE:   pool_base_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GROUP_COUNT: prdata = 32'(group_count_q);
      REG_ENTRY_SIZE:  prdata = 32'(entry_size_q);
      REG_POOL_BASE:   prdata = pool_base_q;
      default:         prdata = '0;
    endcase
  end

  // Entries in use, saturated
  assign groups_sat = (32'(group_count_q) > 32'(MAX_GROUPS)) ? 32'(MAX_GROUPS)
                                                             : 32'(group_count_q);
  assign n_full     = groups_sat * 32'(GROUP_SIZE);
  assign n_cap      = (n_full > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : n_full;

  // Chunk scan
  assign chunk_base = 32'(chunk_q) << SCAN_LOG;

  always_comb begin
    for (int unsigned b = 0; b < SCAN_W; b++) begin
      avail[b] = chunk_bits[b] & ((chunk_base + 32'(b)) < 32'(n_q));
    end
    first = '0;
    for (int b = SCAN_W - 1; b >= 0; b--) begin
      if (avail[b]) begin
        first = SCAN_LOG'(b);
      end
    end
  end

  assign found_pos = chunk_base + 32'(first);

  bfa_arith u_arith (
    .req_i (arith_req),
    .rsp_o (arith_rsp)
  );

  bfa_free_map #(
    .CHUNK_W     (CHUNK_W),
    .IDX_W       (IDX_W)
  ) u_free_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chunk_i      (chunk_q),
    .chunk_bits_o (chunk_bits),
    .op_i         (map_op),
    .idx_i        (map_idx)
  );

  assign idx_ext = 32'(idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chunk_q <= chunk_d;
    idx_q   <= idx_d;
    n_q     <= n_d;
    addr_q  <= addr_d;
    acc_q   <= acc_d;
    span_q  <= span_d;
    k_q     <= k_d;
    ok_q    <= ok_d;
    index_q <= index_d;
    eaddr_q <= eaddr_d;
  end

  always_comb begin
    state_d   = state_q;
    chunk_d   = chunk_q;
    idx_d     = idx_q;
    n_d       = n_q;
    addr_d    = addr_q;
    acc_d     = acc_q;
    span_d    = span_q;
    k_d       = k_q;
    ok_d      = ok_q;
    index_d   = index_q;
    eaddr_d   = eaddr_q;
    arith_req = '{op: ARITH_ADD, a: '0, b: '0};
    map_op    = MAP_HOLD;
    map_idx   = idx_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          addr_d  = release_address_i;
          n_d     = n_cap[CNT_W-1:0];
          chunk_d = '0;
          ok_d    = 1'b0;
          index_d = '0;
          eaddr_d = '0;
          state_d = (func_i == FUNC_ALLOC) ? S_SCAN : S_OFFSET;
        end
      end
      S_SCAN: begin
        if (|avail) begin
          idx_d   = found_pos[IDX_W-1:0];
          map_op  = MAP_TAKE;
          map_idx = found_pos[IDX_W-1:0];
          state_d = S_AMUL;
        end else if ((chunk_base + 32'(SCAN_W)) >= 32'(n_q) ||
                     chunk_q == CHUNK_W'(NCHUNK - 1)) begin
          state_d = S_OUT;
        end else begin
          chunk_d = chunk_q + CHUNK_W'(1);
        end
      end
      S_AMUL: begin
        arith_req = '{op: ARITH_MUL, a: idx_ext, b: 32'(entry_size_q)};
        acc_d     = arith_rsp.res;
        state_d   = S_AADD;
      end
      S_AADD: begin
        arith_req = '{op: ARITH_ADD, a: pool_base_q, b: acc_q};
        eaddr_d   = arith_rsp.res;
        ok_d      = 1'b1;
        index_d   = idx_ext[7:0];
        state_d   = S_OUT;
      end
      S_OFFSET: begin
        arith_req = '{op: ARITH_SUB, a: addr_q, b: pool_base_q};
        acc_d     = arith_rsp.res;
        state_d   = S_SPAN;
      end
      S_SPAN: begin
        arith_req = '{op: ARITH_MUL, a: 32'(n_q), b: 32'(entry_size_q)};
        span_d    = arith_rsp.res;
        state_d   = S_CMP;
      end
      S_CMP: begin
        arith_req = '{op: ARITH_SUB, a: acc_q, b: span_q};
        if (arith_rsp.ge || entry_size_q == '0) begin
          state_d = S_OUT;
        end else begin
          idx_d   = '0;
          k_d     = K_W'(IDX_W - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        arith_req = '{op: ARITH_SUB, a: acc_q, b: 32'(entry_size_q) << k_q};
        if (arith_rsp.ge) begin
          acc_d      = arith_rsp.res;
          idx_d[k_q] = 1'b1;
        end
        if (k_q == '0) begin
          state_d = S_FREE;
        end else begin
          k_d = k_q - K_W'(1);
        end
      end
      S_FREE: begin
        map_op  = MAP_GIVE;
        ok_d    = 1'b1;
        index_d = idx_ext[7:0];
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = (state_q == S_OUT);
  assign ok_o            = ok_q;
  assign entry_index_o   = index_q;
  assign entry_address_o = eaddr_q;

endmodule
